@@ sv/hamming_sec_encode_decode_assert.svh @@
// ----------------------------------------------------------------------------
// Hamming SEC codec assertion macros
// Shorthand for the concurrent checks attached to the codec ports.
// ----------------------------------------------------------------------------
`ifndef HAMMING_SEC_ENCODE_DECODE_ASSERT_SVH
`define HAMMING_SEC_ENCODE_DECODE_ASSERT_SVH

// Check on every rising edge; mute while reset is held low.
`define HSEC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check on every rising edge, through reset as well.
`define HSEC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/hsec_pkg.sv @@
// ----------------------------------------------------------------------------
// Hamming SEC codec package
// Widths, port layout, command codes and code-mapping functions.
// ----------------------------------------------------------------------------
`default_nettype none

package hsec_pkg;

    localparam int CODE_W   = 64;  // codeword width, position p at bit p-1
    localparam int DATA_W   = 57;  // largest data word that fits
    localparam int PAR_W    = 6;   // largest parity count
    localparam int SYN_W    = 7;   // syndrome field width
    localparam int CFG_W    = 6;   // data_bits register width
    localparam int M_TDATA_W = CODE_W + DATA_W + SYN_W;
    localparam int M_TUSER_W = 2;

    // result tdata layout, lowest field first
    localparam int OUT_DATA_LO = CODE_W;
    localparam int OUT_SYN_LO  = CODE_W + DATA_W;
    localparam int OUT_SYN_HI  = M_TDATA_W - 1;

    // result tuser layout
    localparam int USER_ERR = 0;
    localparam int USER_UNC = 1;

    localparam logic [CFG_W-1:0] DBITS_RESET = CFG_W'(4);
    localparam logic [CFG_W-1:0] DBITS_MIN   = CFG_W'(1);
    localparam logic [CFG_W-1:0] DBITS_MAX   = CFG_W'(DATA_W);

    typedef enum logic {
        CMD_ENCODE = 1'b0,
        CMD_DECODE = 1'b1
    } cmd_t;

    // least r with 2^r >= m + r + 1
    function automatic logic [2:0] parity_count(input logic [CFG_W-1:0] m);
        int r;
        int i;
        r = 0;
        for (i = 0; i < 7; i++) begin
            if ((1 << r) < int'(m) + r + 1) begin
                r = r + 1;
            end
        end
        return 3'(r);
    endfunction

    // ones in the lowest n bits
    function automatic logic [CODE_W-1:0] low_mask(input logic [CFG_W-1:0] n);
        logic [CODE_W-1:0] res;
        int i;
        res = '0;
        for (i = 0; i < CODE_W; i++) begin
            res[i] = (i < int'(n));
        end
        return res;
    endfunction

    // place data bits at the non power-of-two positions, ascending
    function automatic logic [CODE_W-1:0] scatter(input logic [DATA_W-1:0] d);
        logic [CODE_W-1:0] w;
        int p;
        int k;
        w = '0;
        k = 0;
        for (p = 1; p < CODE_W; p++) begin
            if ((p & (p - 1)) != 0) begin
                w[p-1] = d[k];
                k = k + 1;
            end
        end
        return w;
    endfunction

    // pull the data bits back out of the non power-of-two positions
    function automatic logic [DATA_W-1:0] gather(input logic [CODE_W-1:0] w);
        logic [DATA_W-1:0] d;
        int p;
        int k;
        d = '0;
        k = 0;
        for (p = 1; p < CODE_W; p++) begin
            if ((p & (p - 1)) != 0) begin
                d[k] = w[p-1];
                k = k + 1;
            end
        end
        return d;
    endfunction

    // bit i is the XOR of every position with bit i of its index set
    function automatic logic [PAR_W-1:0] syndrome_of(input logic [CODE_W-1:0] w);
        logic [PAR_W-1:0] s;
        int i;
        int p;
        s = '0;
        for (i = 0; i < PAR_W; i++) begin
            for (p = 1; p < CODE_W; p++) begin
                if (((p >> i) & 1) != 0) begin
                    s[i] = s[i] ^ w[p-1];
                end
            end
        end
        return s;
    endfunction

    // drop parity bit k onto position 2^k
    function automatic logic [CODE_W-1:0] place_parity(input logic [PAR_W-1:0] s);
        logic [CODE_W-1:0] w;
        int k;
        w = '0;
        for (k = 0; k < PAR_W; k++) begin
            w[(1 << k) - 1] = s[k];
        end
        return w;
    endfunction

endpackage

`default_nettype wire

@@ sv/hamming_sec_encode_decode.sv @@
// ----------------------------------------------------------------------------
// Hamming SEC encoder / decoder
// Each item passes the trim, parity-check and correction stages in order; m_tvalid shows the last.
// Throughput: one item per cycle; a full stage holds only while the one ahead cannot move.
// Reset (aresetn low, synchronous): pipeline emptied, data_bits back to 4.
// ----------------------------------------------------------------------------
`default_nettype none

module hamming_sec_encode_decode
    import hsec_pkg::*;
(
    input  wire                    aclk,
    input  wire                    aresetn,

    // input items
    input  wire                    s_tvalid,
    output logic                   s_tready,
    input  wire  [CODE_W-1:0]      s_tdata,   // [63:0] payload
    input  wire                    s_tuser,   // [0] cmd

    // result items
    output logic                   m_tvalid,
    input  wire                    m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // [63:0] code_word, [120:64] data_out,
                                              // [127:121] syndrome
    output logic [M_TUSER_W-1:0]   m_tuser,   // [0] error_found, [1] uncorrectable

    // data_bits register
    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire  [CFG_W-1:0]       cfg_data
);

    // ------------------------------------------------------------------
    // Configuration: keep only what the datapath needs, worked out once
    // at the write. Zero acts as one data bit, anything past the largest
    // fitting word acts as that word.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]  n_reg;       // code length
    logic [CODE_W-1:0] nmask_reg;   // code positions in use
    logic [DATA_W-1:0] dmask_reg;   // data bits in use

    logic [CFG_W-1:0]  m_eff;
    logic [CFG_W-1:0]  n_next;
    logic [CODE_W-1:0] nmask_next;
    logic [DATA_W-1:0] dmask_next;
    logic [CODE_W-1:0] dmask_wide;

    always_comb begin
        if (cfg_data < DBITS_MIN) begin
            m_eff = DBITS_MIN;
        end else if (cfg_data > DBITS_MAX) begin
            m_eff = DBITS_MAX;
        end else begin
            m_eff = cfg_data;
        end
        n_next     = m_eff + CFG_W'(parity_count(m_eff));
        nmask_next = low_mask(n_next);
        dmask_wide = low_mask(m_eff);
        dmask_next = dmask_wide[DATA_W-1:0];
    end

    // the user must write only with the pipeline idle; the block does not enforce it and accepts writes at once
    assign cfg_ready = 1'b1;

    logic [CODE_W-1:0] rst_dmask_wide;
    assign rst_dmask_wide = low_mask(DBITS_RESET);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg     <= DBITS_RESET + CFG_W'(parity_count(DBITS_RESET));
            nmask_reg <= low_mask(DBITS_RESET + CFG_W'(parity_count(DBITS_RESET)));
            dmask_reg <= rst_dmask_wide[DATA_W-1:0];
        end else if (cfg_valid && cfg_ready) begin
            n_reg     <= n_next;
            nmask_reg <= nmask_next;
            dmask_reg <= dmask_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake: a stage takes a new item when it is empty or its
    // own item moves on in the same cycle. Bubbles close up while the
    // output is stalled.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    assign rdy3     = !v3_reg || m_tready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign m_tvalid = v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_tvalid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: trim the payload to the configured length. Encode spreads
    // the data bits over the non power-of-two positions with the parity
    // positions left at zero; decode takes the received word as it is.
    // ------------------------------------------------------------------
    cmd_t              cmd_in;
    logic [DATA_W-1:0] dat_in;
    logic [CODE_W-1:0] word1_next;

    cmd_t              cmd1_reg;
    logic [CODE_W-1:0] word1_reg;
    logic [DATA_W-1:0] dat1_reg;

    always_comb begin
        cmd_in = cmd_t'(s_tuser);
        dat_in = s_tdata[DATA_W-1:0] & dmask_reg;
        if (cmd_in == CMD_DECODE) begin
            word1_next = s_tdata & nmask_reg;
        end else begin
            word1_next = scatter(dat_in);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            cmd1_reg  <= cmd_in;
            word1_reg <= word1_next;
            dat1_reg  <= dat_in;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: parity checks. Positions past the code length are already
    // zero, so checks above the parity count come out zero by themselves.
    // On encode the result is the parity set itself.
    // ------------------------------------------------------------------
    cmd_t              cmd2_reg;
    logic [CODE_W-1:0] word2_reg;
    logic [DATA_W-1:0] dat2_reg;
    logic [PAR_W-1:0]  syn2_reg;

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            cmd2_reg  <= cmd1_reg;
            word2_reg <= word1_reg;
            dat2_reg  <= dat1_reg;
            syn2_reg  <= syndrome_of(word1_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: encode drops the parity bits in; decode flags a syndrome
    // past the code length, otherwise flips the named position, then
    // pulls the data bits out.
    // ------------------------------------------------------------------
    logic              unc3;
    logic              fix3;
    logic [CODE_W-1:0] flip3;
    logic [CODE_W-1:0] fixed3;
    logic [CODE_W-1:0] code3_next;
    logic [DATA_W-1:0] data3_next;
    logic [SYN_W-1:0]  syn3_next;
    logic              err3_next;

    always_comb begin
        unc3   = (syn2_reg > n_reg);
        fix3   = (syn2_reg != '0) && !unc3;
        flip3  = fix3 ? (CODE_W'(1) << (syn2_reg - PAR_W'(1))) : '0;
        fixed3 = word2_reg ^ flip3;
        if (cmd2_reg == CMD_DECODE) begin
            code3_next = fixed3;
            data3_next = gather(fixed3);
            syn3_next  = SYN_W'(syn2_reg);
            err3_next  = (syn2_reg != '0);
        end else begin
            code3_next = word2_reg | place_parity(syn2_reg);
            data3_next = dat2_reg;
            syn3_next  = '0;
            err3_next  = 1'b0;
            unc3       = 1'b0;
        end
    end

    logic [CODE_W-1:0] code3_reg;
    logic [DATA_W-1:0] data3_reg;
    logic [SYN_W-1:0]  syn3_reg;
    logic              err3_reg;
    logic              unc3_reg;

    // hold the result while the sink stalls
    always_ff @(posedge aclk) begin
        if (rdy3) begin
            code3_reg <= code3_next;
            data3_reg <= data3_next;
            syn3_reg  <= syn3_next;
            err3_reg  <= err3_next;
            unc3_reg  <= unc3;
        end
    end

    assign m_tdata = {syn3_reg, data3_reg, code3_reg};

    always_comb begin
        m_tuser           = '0;
        m_tuser[USER_ERR] = err3_reg;
        m_tuser[USER_UNC] = unc3_reg;
    end

endmodule

`default_nettype wire

@@ sv/hsec_checker.sv @@
// ----------------------------------------------------------------------------
// Hamming SEC codec port checker
// Watches the result channel of the codec over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hamming_sec_encode_decode_assert.svh"

module hsec_checker
    import hsec_pkg::*;
(
    input wire                  aclk,
    input wire                  aresetn,
    input wire                  m_tvalid,
    input wire                  m_tready,
    input wire [M_TDATA_W-1:0]  m_tdata,
    input wire [M_TUSER_W-1:0]  m_tuser
);

    // a stalled result stays offered
    `HSEC_ASSERT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")

    // and its contents do not move
    `HSEC_ASSERT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed while stalled")

    // error flag follows the syndrome
    `HSEC_ASSERT(a_err_syn, aclk, aresetn, m_tvalid |-> (m_tuser[USER_ERR] == (m_tdata[OUT_SYN_HI:OUT_SYN_LO] != '0)), "error flag disagrees with syndrome")

    // an uncorrectable word is always an erroneous one
    `HSEC_ASSERT(a_unc_err, aclk, aresetn, m_tvalid && m_tuser[USER_UNC] |-> m_tuser[USER_ERR], "uncorrectable without error")

    // reset empties the pipeline
    `HSEC_ASSERT_ALWAYS(a_rst_empty, aclk, !aresetn |=> !m_tvalid, "result offered after reset")

endmodule

bind hamming_sec_encode_decode hsec_checker u_hsec_checker (.*);

`default_nettype wire
